// ===== design/nfva_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfva_pkg: shared types and constants for the nearest free value allocator
// Status codes, default table depth, and the controller-to-datapath structs.
// ----------------------------------------------------------------------------
package nfva_pkg;

	localparam int MaxRangesDefault = 64;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_GET  = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;   // latch the input word, clear the scan
		logic scan_rd;   // issue a read of entry scan index
		logic scan_chk;  // evaluate the returned entry
		logic decide;    // work out the action and result
		logic mv_rd;     // read the entry feeding a shift step
		logic mv_wr;     // write the shifted entry
		logic fin_wr;    // write the final entry
	} nfva_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic scan_last;  // last entry read issued
		logic empty;      // table empty
		logic act_none;   // no table change
		logic act_open;   // open an entry at the target
		logic act_drop;   // remove the entry at the target
		logic mv_done;    // no more shift steps
	} nfva_sts_t;

endpackage

// ===== design/nfva_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfva_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module nfva_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/nfva_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfva_datapath: range table and search logic
// Scans the sorted table entry by entry, then applies insert, shrink,
// split or delete, shifting entries one a step.
// ----------------------------------------------------------------------------
module nfva_datapath #(
	parameter int MaxRanges = nfva_pkg::MaxRangesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  nfva_pkg::nfva_cmd_t cmd,
	output nfva_pkg::nfva_sts_t sts,
	input  logic                req_type,
	input  logic [31:0]         range_low,
	input  logic [31:0]         range_high,
	input  logic [31:0]         wanted_value,
	output logic [31:0]         res_value,
	output logic [1:0]          res_status,
	output logic                split_more
);
	import nfva_pkg::*;

	localparam int AW = $clog2(MaxRanges);
	localparam int CW = $clog2(MaxRanges + 1);

	logic [CW-1:0] count_q;
	logic          kind_q;
	logic [31:0]   lo_q, hi_q, w_q;
	logic [CW-1:0] idx_q;      // next entry to read
	logic [AW-1:0] chk_idx_q;  // entry whose data is on the read port
	logic [CW-1:0] pos_q;      // first entry with low above key
	logic          ovl_q;
	logic [31:0]   plo_q, phi_q; // entry pos-1
	logic [31:0]   nlo_q, nhi_q; // entry pos
	logic          nseen_q;
	logic [CW-1:0] tgt_q;       // entry the final write touches
	logic [31:0]   flo_q, fhi_q;
	logic [CW-1:0] mv_q;        // shift cursor
	logic          open_q, drop_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wlo, whi, rlo, rhi;

	nfva_ram #(.Width(32), .Depth(MaxRanges)) u_lo (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wlo), .raddr(raddr), .rdata(rlo));
	nfva_ram #(.Width(32), .Depth(MaxRanges)) u_hi (
		.clk(clk), .we(we), .waddr(waddr), .wdata(whi), .raddr(raddr), .rdata(rhi));

	logic [31:0] key;
	assign key = (kind_q == REQ_LOAD) ? lo_q : w_q;

	// read address: scan cursor, or the source of a shift step
	always_comb begin
		raddr = idx_q[AW-1:0];
		if (cmd.mv_rd) begin
			raddr = open_q ? AW'(mv_q - CW'(1)) : AW'(mv_q + CW'(1));
		end
	end

	// write port
	always_comb begin
		we    = cmd.mv_wr | cmd.fin_wr;
		waddr = cmd.fin_wr ? tgt_q[AW-1:0] : mv_q[AW-1:0];
		wlo   = cmd.fin_wr ? flo_q : rlo;
		whi   = cmd.fin_wr ? fhi_q : rhi;
	end

	assign sts.scan_last = (idx_q + CW'(1) >= count_q);
	assign sts.empty     = (count_q == '0);
	assign sts.mv_done   = open_q ? (mv_q <= tgt_q)
	                              : (mv_q >= count_q);

	// decision, from scan results
	logic          d_none, d_open, d_drop, d_below;
	logic [1:0]    d_st;
	logic [31:0]   d_val, d_flo, d_fhi;
	logic [CW-1:0] d_tgt;
	logic          full;
	logic [32:0]   dbelow, dabove;
	assign full   = (count_q == CW'(MaxRanges));
	assign dbelow = {1'b0, w_q} - {1'b0, phi_q};
	assign dabove = {1'b0, nlo_q} - {1'b0, w_q};

	always_comb begin
		d_none = 1'b1; d_open = 1'b0; d_drop = 1'b0;
		d_st = ST_OK; d_val = '0;
		d_tgt = pos_q; d_flo = lo_q; d_fhi = hi_q;
		d_below = 1'b0;
		if (kind_q == REQ_LOAD) begin
			if (lo_q <= hi_q && !ovl_q) begin
				if (full) begin
					d_st = ST_FULL;
				end else begin
					d_none = 1'b0; d_open = 1'b1;
				end
			end
		end else if (count_q == '0) begin
			d_st = ST_EMPTY;
		end else if (pos_q != '0 && phi_q >= w_q) begin
			d_tgt = pos_q - CW'(1);
			if (plo_q == w_q && phi_q == w_q) begin
				d_none = 1'b0; d_drop = 1'b1; d_val = w_q;
			end else if (plo_q == w_q) begin
				d_none = 1'b0; d_flo = w_q + 32'd1; d_fhi = phi_q; d_val = w_q;
			end else if (phi_q == w_q) begin
				d_none = 1'b0; d_flo = plo_q; d_fhi = w_q - 32'd1; d_val = w_q;
			end else if (full) begin
				d_st = ST_FULL;
			end else begin
				// shrink entry pos-1 by a separate write is folded: open new entry at
				// pos holding w+1..hi, then rewrite pos-1 during the final stage
				d_none = 1'b0; d_open = 1'b1; d_tgt = pos_q;
				d_flo = w_q + 32'd1; d_fhi = phi_q; d_val = w_q;
			end
		end else begin
			if (pos_q == '0) d_below = 1'b0;
			else if (pos_q >= count_q) d_below = 1'b1;
			else d_below = (dbelow <= dabove);
			d_none = 1'b0;
			if (d_below) begin
				d_tgt = pos_q - CW'(1); d_val = phi_q;
				d_flo = plo_q; d_fhi = phi_q - 32'd1;
				d_drop = (plo_q == phi_q);
			end else begin
				d_tgt = pos_q; d_val = nlo_q;
				d_flo = nlo_q + 32'd1; d_fhi = nhi_q;
				d_drop = (nlo_q == nhi_q);
			end
		end
	end

	assign sts.act_none = d_none;
	assign sts.act_open = d_open;
	assign sts.act_drop = d_drop;

	// a split also needs entry pos-1 trimmed; done as a second final write
	logic split_q, split_fix_q;

	// control and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q <= '0;
			split_q <= 1'b0;
			split_fix_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
				split_q <= 1'b0;
			end
			if (cmd.scan_rd) idx_q <= idx_q + CW'(1);
			if (cmd.decide) begin
				split_q <= (kind_q == REQ_GET) && d_open;
				if (d_open) count_q <= count_q + CW'(1);
				if (d_drop) count_q <= count_q - CW'(1);
			end
			if (cmd.fin_wr) split_fix_q <= split_q && !split_fix_q;
			if (cmd.capture) split_fix_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req_type; lo_q <= range_low; hi_q <= range_high; w_q <= wanted_value;
			pos_q <= '0; ovl_q <= 1'b0; nseen_q <= 1'b0;
		end
		if (cmd.scan_rd) chk_idx_q <= idx_q[AW-1:0];
		if (cmd.scan_chk) begin
			if (rlo <= hi_q && lo_q <= rhi && kind_q == REQ_LOAD) ovl_q <= 1'b1;
			if (rlo <= key) begin
				pos_q <= CW'(chk_idx_q) + CW'(1);
				plo_q <= rlo; phi_q <= rhi;
			end else if (!nseen_q) begin
				nseen_q <= 1'b1; nlo_q <= rlo; nhi_q <= rhi;
			end
		end
		if (cmd.decide) begin
			res_value <= d_val; res_status <= d_st;
			tgt_q <= d_tgt; flo_q <= d_flo; fhi_q <= d_fhi;
			open_q <= d_open; drop_q <= d_drop;
			// count before update: open shifts down from count, drop from target
			mv_q <= d_open ? count_q : d_tgt;
		end
		if (cmd.mv_wr) mv_q <= drop_q ? mv_q + CW'(1) : mv_q - CW'(1);
		if (cmd.fin_wr && split_q && !split_fix_q) begin
			tgt_q <= pos_q - CW'(1); flo_q <= plo_q; fhi_q <= w_q - 32'd1;
		end
	end

	assign split_more = split_q && !split_fix_q;
endmodule

// ===== design/nfva_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfva_ctrl: sequencer for the allocator
// Steps through capture, table scan, decision, shift and final write.
// ----------------------------------------------------------------------------
module nfva_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  logic                split_more,
	input  nfva_pkg::nfva_sts_t sts,
	output nfva_pkg::nfva_cmd_t cmd
);
	import nfva_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_CHK  = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_MVR  = 3'd4;
	localparam logic [2:0] S_MVW  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q, state_d;
	logic       busy_q;
	logic       last_q;
	logic       out_valid_q;
	logic       acc, shift_q;

	// accept when the sequencer is free and the result slot can take a word
	assign in_stall  = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: if (acc) begin
				cmd.capture = 1'b1; state_d = S_SCAN;
			end
			S_SCAN: begin
				if (sts.empty) begin
					state_d = S_DEC;
				end else begin
					cmd.scan_rd = 1'b1; state_d = S_CHK;
				end
			end
			S_CHK: begin
				cmd.scan_chk = 1'b1;
				state_d = last_q ? S_DEC : S_SCAN;
			end
			S_DEC: begin
				cmd.decide = 1'b1;
				if (sts.act_none) state_d = S_IDLE;
				else if (sts.act_open || sts.act_drop) state_d = S_MVR;
				else state_d = S_FIN;
			end
			S_MVR: begin
				if (sts.mv_done) begin
					state_d = shift_q ? S_IDLE : S_FIN;
				end else begin
					cmd.mv_rd = 1'b1; state_d = S_MVW;
				end
			end
			S_MVW: begin
				cmd.mv_wr = 1'b1; state_d = S_MVR;
			end
			S_FIN: begin
				cmd.fin_wr = 1'b1;
				state_d = split_more ? S_FIN : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
			last_q <= 1'b0;
			out_valid_q <= 1'b0;
			shift_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.scan_rd) last_q <= sts.scan_last;
			if (cmd.decide) shift_q <= sts.act_drop;
			if (cmd.capture) busy_q <= 1'b1;
			// present the word when the item leaves the sequencer
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (busy_q && state_q != S_IDLE && state_d == S_IDLE) begin
				out_valid_q <= 1'b1; busy_q <= 1'b0;
			end
		end
	end
endmodule

// ===== design/nearest_free_value_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_free_value_allocator_top: nearest free value allocator
// Sorted table of disjoint free ranges; loads insert, requests take the
// free value nearest the wanted one.
//
//   channel | valid     | stall     | word
//   in      | in_valid  | in_stall  | req_type, range_low, range_high, wanted_value
//   out     | out_valid | out_stall | granted_value, status
//
// Capture is followed by a scan of the N stored ranges (one RAM read and
// one check each) and the decision; an empty table skips the scan.
// Insert and removal then shift entries, a read and a write each step. A
// removal ends there; others end in the final entry write, twice for a split.
// Reset clears the range count; the table RAM needs no clearing.
// The input stalls while an item is in flight or a result waits under out_stall.
// ----------------------------------------------------------------------------
module nearest_free_value_allocator_top #(
	parameter int MaxRanges = nfva_pkg::MaxRangesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] range_low,
	input  logic [31:0] range_high,
	input  logic [31:0] wanted_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] granted_value,
	output logic [1:0]  status
);
	import nfva_pkg::*;

	nfva_cmd_t cmd;
	nfva_sts_t sts;
	logic      split_more;

	nfva_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.split_more(split_more), .sts(sts), .cmd(cmd));

	nfva_datapath #(.MaxRanges(MaxRanges)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.req_type(req_type), .range_low(range_low), .range_high(range_high),
		.wanted_value(wanted_value),
		.res_value(granted_value), .res_status(status),
		.split_more(split_more));
endmodule

// ===== tb/sv/nearest_free_value_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_free_value_allocator_top_tb: self-checking bench for the allocator
// Loads free ranges and requests values. A local copy of the range table
// predicts each grant and status. Input and output handshakes idle at random
// in several phases, with one long output hold-off and drains within and between phases.
// ----------------------------------------------------------------------------
module nearest_free_value_allocator_top_tb;
	import nfva_pkg::*;

	localparam int Depth = MaxRangesDefault;

	typedef struct {
		logic        kind;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] want;
	} word_t;

	typedef struct {
		logic [31:0] grant;
		logic [1:0]  st;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = REQ_LOAD;
	logic [31:0] range_low = '0;
	logic [31:0] range_high = '0;
	logic [31:0] wanted_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] granted_value;
	logic [1:0]  status;

	word_t  pending_words[$];
	grant_t expected_grants[$];
	int     errors = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	int     hold_cycles = 0;
	bit     send_pause = 1'b0;

	// predictor copy of the free table
	logic [31:0] free_lo[Depth + 1];
	logic [31:0] free_hi[Depth + 1];
	int          free_cnt = 0;

	nearest_free_value_allocator_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .range_low(range_low),
		.range_high(range_high), .wanted_value(wanted_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.granted_value(granted_value), .status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void remove_range(int i);
		for (int k = i; k + 1 < free_cnt; k++) begin
			free_lo[k] = free_lo[k + 1];
			free_hi[k] = free_hi[k + 1];
		end
		free_cnt--;
	endfunction

	function automatic void insert_range(int i, logic [31:0] lo, logic [31:0] hi);
		for (int k = free_cnt; k > i; k--) begin
			free_lo[k] = free_lo[k - 1];
			free_hi[k] = free_hi[k - 1];
		end
		free_lo[i] = lo;
		free_hi[i] = hi;
		free_cnt++;
	endfunction

	// work out grant and status for one word, updating the table
	function automatic grant_t allocate_nearest(word_t w);
		grant_t r;
		int pos;
		logic [32:0] d_below, d_above;
		bit below;
		r.grant = '0;
		r.st = ST_OK;
		if (w.kind == REQ_LOAD) begin
			if (w.lo > w.hi) return r;
			for (int i = 0; i < free_cnt; i++)
				if (free_lo[i] <= w.hi && w.lo <= free_hi[i]) return r;
			if (free_cnt >= Depth) begin
				r.st = ST_FULL;
				return r;
			end
			pos = 0;
			while (pos < free_cnt && free_lo[pos] <= w.lo) pos++;
			insert_range(pos, w.lo, w.hi);
			return r;
		end
		if (free_cnt == 0) begin
			r.st = ST_EMPTY;
			return r;
		end
		pos = 0;
		while (pos < free_cnt && free_lo[pos] <= w.want) pos++;
		if (pos > 0 && free_hi[pos - 1] >= w.want) begin
			int i = pos - 1;
			if (free_lo[i] == w.want && free_hi[i] == w.want) remove_range(i);
			else if (free_lo[i] == w.want) free_lo[i] = w.want + 1;
			else if (free_hi[i] == w.want) free_hi[i] = w.want - 1;
			else begin
				if (free_cnt >= Depth) begin
					r.st = ST_FULL;
					return r;
				end
				insert_range(i + 1, w.want + 1, free_hi[i]);
				free_hi[i] = w.want - 1;
			end
			r.grant = w.want;
			return r;
		end
		if (pos == 0) below = 1'b0;
		else if (pos >= free_cnt) below = 1'b1;
		else begin
			d_below = {1'b0, w.want} - {1'b0, free_hi[pos - 1]};
			d_above = {1'b0, free_lo[pos]} - {1'b0, w.want};
			below = d_below <= d_above;
		end
		if (below) begin
			r.grant = free_hi[pos - 1];
			if (free_lo[pos - 1] == free_hi[pos - 1]) remove_range(pos - 1);
			else free_hi[pos - 1]--;
		end else begin
			r.grant = free_lo[pos];
			if (free_lo[pos] == free_hi[pos]) remove_range(pos);
			else free_lo[pos]++;
		end
		return r;
	endfunction

	function automatic word_t mk(logic kind, logic [31:0] lo, logic [31:0] hi,
			logic [31:0] want);
		word_t w;
		w.kind = kind;
		w.lo = lo;
		w.hi = hi;
		w.want = want;
		return w;
	endfunction

	function automatic logic [31:0] rnd_val(logic [31:0] base);
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return base + $urandom_range(0, 600);
			2: return ($urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 40) :
				$urandom_range(0, 40));
			default: return base + $urandom_range(0, 60);
		endcase
	endfunction

	// build one random word around a random base
	function automatic word_t rnd_word(logic [31:0] base);
		logic [31:0] a, b;
		a = rnd_val(base);
		if ($urandom_range(0, 99) < 45) begin
			b = ($urandom_range(0, 19) == 0) ? a - $urandom_range(1, 5) :
				a + $urandom_range(0, 30);
			if ($urandom_range(0, 19) == 0) b = $urandom;
			return mk(REQ_LOAD, a, b, $urandom);
		end
		return mk(REQ_GET, $urandom, $urandom, a);
	endfunction

	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || expected_grants.size() != 0)
			@(posedge clk);
	endtask

	// driver: offer the next pending word, hold while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (pending_words.size() != 0 && !send_pause &&
						$urandom_range(0, 99) >= send_idle_pct) begin
					word_t w;
					w = pending_words.pop_front();
					expected_grants.push_back(allocate_nearest(w));
					in_valid <= 1'b1;
					req_type <= w.kind;
					range_low <= w.lo;
					range_high <= w.hi;
					wanted_value <= w.want;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: long hold-off or random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_grants.size() == 0) begin
				$error("unexpected result granted_value=%0h status=%0d",
					granted_value, status);
				errors++;
			end else begin
				grant_t e;
				e = expected_grants.pop_front();
				if (granted_value !== e.grant) begin
					$error("granted_value expected %0h actual %0h", e.grant, granted_value);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		logic [31:0] base;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, extremes, splits, single values, overlaps
		pending_words.push_back(mk(REQ_GET, 0, 0, 32'h1234));
		pending_words.push_back(mk(REQ_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0));
		pending_words.push_back(mk(REQ_LOAD, 0, 0, 0));
		pending_words.push_back(mk(REQ_LOAD, 100, 50, 0));
		pending_words.push_back(mk(REQ_LOAD, 0, 32'hFFFF_FFFF, 0));
		pending_words.push_back(mk(REQ_LOAD, 0, 0, 0));
		pending_words.push_back(mk(REQ_LOAD, 10, 20, 0));
		pending_words.push_back(mk(REQ_LOAD, 15, 30, 0));
		pending_words.push_back(mk(REQ_LOAD, 40, 40, 0));
		pending_words.push_back(mk(REQ_GET, 0, 0, 15));
		pending_words.push_back(mk(REQ_GET, 0, 0, 10));
		pending_words.push_back(mk(REQ_GET, 0, 0, 20));
		pending_words.push_back(mk(REQ_GET, 0, 0, 30));
		pending_words.push_back(mk(REQ_GET, 0, 0, 25));
		pending_words.push_back(mk(REQ_GET, 0, 0, 32'h8000_0000));
		pending_words.push_back(mk(REQ_GET, 0, 0, 32'hFFFF_FFFF));
		pending_words.push_back(mk(REQ_GET, 0, 0, 0));
		pending_words.push_back(mk(REQ_GET, 0, 0, 5));
		for (int i = 0; i < 6; i++) pending_words.push_back(mk(REQ_GET, 0, 0, 1));
		wait_drained();

		// random phases, each with its own input and output idle rates
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_idle_pct = 0; end
				1: begin send_idle_pct = 77; recv_idle_pct = 0; end
				2: begin send_idle_pct = 0; recv_idle_pct = 77; end
				3: begin send_idle_pct = 38; recv_idle_pct = 38; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			base = $urandom;
			// fill toward full so table-full paths are reached
			for (int i = 0; i < 80; i++)
				pending_words.push_back(mk(REQ_LOAD, base + 4 * i, base + 4 * i + 2, 0));
			if (ph == 0) hold_cycles = 3000;
			for (int i = 0; i < 160; i++) begin
				if (i == 80) begin
					wait_drained();
					send_pause = 1'b1;
					repeat (5) @(posedge clk);
					send_pause = 1'b0;
				end
				pending_words.push_back(rnd_word(base));
			end
			wait_drained();
		end
		repeat (400) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
